@@ src/heightmap_surface_normal_assert.svh @@
// Assertion macros used by the heightmap surface normal checker
`ifndef HEIGHTMAP_SURFACE_NORMAL_ASSERT_SVH
`define HEIGHTMAP_SURFACE_NORMAL_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define HSN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define HSN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hsn_pkg.sv @@
// Shared widths, constants and types of the heightmap surface normal block
`default_nettype none

package hsn_pkg;

    // Grid geometry
    localparam int MAX_GRID   = 256;
    localparam int MIN_GRID   = 2;
    localparam int IDX_W      = $clog2(MAX_GRID);
    localparam int GRID_W     = 9;
    localparam int CELL_W     = 8;

    // Height samples, Q8.8
    localparam int HEIGHT_W   = 16;
    localparam int HEIGHT_FRAC = 8;

    // Corner difference sums and their squares
    localparam int DIFF_W     = HEIGHT_W + 2;
    localparam int MAG_W      = DIFF_W - 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int REM_W      = SUM_W + 1;

    // Vertical component of the unnormalized vector, scaled, and its square
    localparam int Y_MAG      = 2 << HEIGHT_FRAC;
    localparam int Y_SQ       = Y_MAG * Y_MAG;

    // Division and square root sequencing
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = 31;
    localparam int ROOT_W     = 16;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Normal components, Q1.14
    localparam int Q_W        = 15;
    localparam int OUT_W      = 16;

    // Component being normalized
    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2
    } t_comp;

    // One cell handed from the grid tracker to the normalizer
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dz;
        logic [CELL_W-1:0]        row;
        logic [CELL_W-1:0]        col;
        logic                     last;
    } t_cell_job;

endpackage

`default_nettype wire

@@ src/hsn_ifs.sv @@
// Valid/ready channel interfaces of the heightmap surface normal block
`default_nettype none

interface hsn_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hsn_pkg::HEIGHT_W-1:0]    height_sample;
    logic                                   grid_start;

    modport source (output valid, output height_sample, output grid_start, input ready);
    modport sink   (input valid, input height_sample, input grid_start, output ready);
endinterface

interface hsn_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hsn_pkg::GRID_W-1:0]     grid_size;

    modport source (output valid, output grid_size, input ready);
    modport sink   (input valid, input grid_size, output ready);
endinterface

interface hsn_normal_if;
    logic                               valid;
    logic                               ready;
    logic signed [hsn_pkg::OUT_W-1:0]   normal_x;
    logic [hsn_pkg::Q_W-1:0]            normal_y;
    logic signed [hsn_pkg::OUT_W-1:0]   normal_z;
    logic [hsn_pkg::CELL_W-1:0]         cell_row;
    logic [hsn_pkg::CELL_W-1:0]         cell_col;
    logic                               last_cell;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output cell_row, output cell_col, output last_cell, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input cell_row, input cell_col, input last_cell, output ready);
endinterface

`default_nettype wire

@@ src/hsn_grid_track.sv @@
// Grid position tracking, previous-row store and corner differences
`default_nettype none

module hsn_grid_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hsn_cfg_if.sink             i_cfg,
    hsn_sample_if.sink          i_sample,
    input  logic                i_norm_busy,
    output logic                o_job_valid,
    output hsn_pkg::t_cell_job  o_job
);
    import hsn_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_READ = 3'b010,
        T_CALC = 3'b100
    } t_track_state;

    t_track_state               r_state, n_state;
    logic [GRID_W-1:0]          r_grid_size;
    logic [IDX_W-1:0]           r_row, n_row;
    logic [IDX_W-1:0]           r_col, n_col;
    logic [IDX_W-1:0]           r_pos_row, n_pos_row;
    logic [IDX_W-1:0]           r_pos_col, n_pos_col;
    logic signed [HEIGHT_W-1:0] r_h;
    logic signed [HEIGHT_W-1:0] r_up;
    logic signed [HEIGHT_W-1:0] r_left;
    logic signed [HEIGHT_W-1:0] r_upleft;
    logic signed [HEIGHT_W-1:0] r_row_store [MAX_GRID];

    logic                       in_accept;
    logic                       cfg_accept;
    logic [GRID_W-1:0]          sz;
    logic [GRID_W-1:0]          adj_col, adj_row;
    logic [GRID_W-1:0]          inc_col, inc_row;
    logic                       is_cell;
    logic                       is_last;
    logic signed [DIFF_W-1:0]   e_h00, e_h01, e_h10, e_h11;

    // Handshakes
    assign i_cfg.ready    = 1'b1;
    assign cfg_accept     = i_cfg.valid && i_cfg.ready;
    assign i_sample.ready = (r_state == T_IDLE) && !i_norm_busy;
    assign in_accept      = i_sample.valid && i_sample.ready;

    // Clamp the grid size to the supported range
    always_comb begin
        if (r_grid_size < GRID_W'(MIN_GRID)) begin
            sz = GRID_W'(MIN_GRID);
        end else if (r_grid_size > GRID_W'(MAX_GRID)) begin
            sz = GRID_W'(MAX_GRID);
        end else begin
            sz = r_grid_size;
        end
    end

    // Fix up the position of an incoming sample against start flag and size
    always_comb begin
        adj_col = GRID_W'(r_col);
        adj_row = GRID_W'(r_row);
        if (i_sample.grid_start) begin
            adj_col = '0;
            adj_row = '0;
        end
        if (adj_col >= sz) begin
            adj_col = '0;
            adj_row = adj_row + GRID_W'(1);
        end
        if (adj_row >= sz) begin
            adj_row = '0;
        end
        n_pos_col = adj_col[IDX_W-1:0];
        n_pos_row = adj_row[IDX_W-1:0];
    end

    // Advance to the following grid position
    always_comb begin
        inc_col = GRID_W'(r_pos_col) + GRID_W'(1);
        inc_row = GRID_W'(r_pos_row);
        if (inc_col >= sz) begin
            inc_col = '0;
            inc_row = inc_row + GRID_W'(1);
            if (inc_row >= sz) begin
                inc_row = '0;
            end
        end
        n_col = inc_col[IDX_W-1:0];
        n_row = inc_row[IDX_W-1:0];
    end

    // Build the cell from its four corners
    assign is_cell = (r_pos_row != '0) && (r_pos_col != '0);
    assign is_last = (GRID_W'(r_pos_row) == sz - GRID_W'(1))
                  && (GRID_W'(r_pos_col) == sz - GRID_W'(1));
    assign e_h00 = {{(DIFF_W-HEIGHT_W){r_upleft[HEIGHT_W-1]}}, r_upleft};
    assign e_h01 = {{(DIFF_W-HEIGHT_W){r_up[HEIGHT_W-1]}}, r_up};
    assign e_h10 = {{(DIFF_W-HEIGHT_W){r_left[HEIGHT_W-1]}}, r_left};
    assign e_h11 = {{(DIFF_W-HEIGHT_W){r_h[HEIGHT_W-1]}}, r_h};

    assign o_job_valid = (r_state == T_CALC) && is_cell;
    assign o_job.dx    = e_h10 + e_h11 - e_h00 - e_h01;
    assign o_job.dz    = e_h01 + e_h11 - e_h00 - e_h10;
    assign o_job.row   = CELL_W'(r_pos_row - IDX_W'(1));
    assign o_job.col   = CELL_W'(r_pos_col - IDX_W'(1));
    assign o_job.last  = is_last;

    // Sequence: take sample, read row store, update neighbors
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (in_accept) begin
                    n_state = T_READ;
                end
            end
            T_READ: begin
                n_state = T_CALC;
            end
            T_CALC: begin
                n_state = T_IDLE;
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    // Control and neighbor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_grid_size <= GRID_W'(MAX_GRID);
            r_row       <= '0;
            r_col       <= '0;
            r_left      <= '0;
            r_upleft    <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_accept) begin
                r_grid_size <= i_cfg.grid_size;
            end
            if (r_state == T_CALC) begin
                r_row    <= n_row;
                r_col    <= n_col;
                r_left   <= r_h;
                r_upleft <= r_up;
            end
        end
    end

    // Hold the sample and its position
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_h       <= i_sample.height_sample;
            r_pos_row <= n_pos_row;
            r_pos_col <= n_pos_col;
        end
    end

    // Previous-row store: registered read, write back the current sample
    always_ff @(posedge i_clk) begin
        if (r_state == T_READ) begin
            r_up <= r_row_store[r_pos_col];
        end
        if (r_state == T_CALC) begin
            r_row_store[r_pos_col] <= r_h;
        end
    end

endmodule

`default_nettype wire

@@ src/hsn_normalize.sv @@
// Iterative normalizer: squares, then restoring divide and square root per component
`default_nettype none

module hsn_normalize (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  hsn_pkg::t_cell_job  i_job,
    output logic                o_busy,
    hsn_normal_if.source        o_normal
);
    import hsn_pkg::*;

    typedef enum logic [7:0] {
        N_IDLE  = 8'b0000_0001,
        N_SQX   = 8'b0000_0010,
        N_SQZ   = 8'b0000_0100,
        N_SUM   = 8'b0000_1000,
        N_DIV   = 8'b0001_0000,
        N_SQRT  = 8'b0010_0000,
        N_STORE = 8'b0100_0000,
        N_DONE  = 8'b1000_0000
    } t_norm_state;

    t_norm_state                r_state, n_state;
    t_comp                      r_comp, n_comp;
    logic [STEP_W-1:0]          r_step, n_step;
    logic [MAG_W-1:0]           r_adx, r_adz;
    logic                       r_neg_x, r_neg_z;
    logic [CELL_W-1:0]          r_row, r_col;
    logic                       r_last;
    logic [SQ_W-1:0]            r_sqx, n_sqx;
    logic [SQ_W-1:0]            r_sqz, n_sqz;
    logic [SUM_W-1:0]           r_s, n_s;
    logic [REM_W-1:0]           r_rem, n_rem;
    logic [QUO_W-1:0]           r_quo, n_quo;
    logic [ROOT_W-1:0]          r_root, n_root;
    logic [Q_W-1:0]             r_qx, r_qy, r_qz;
    logic [Q_W-1:0]             n_qx, n_qy, n_qz;

    logic                       r_out_valid, n_out_valid;
    logic                       out_load;
    logic signed [OUT_W-1:0]    r_nx, r_nz;
    logic [Q_W-1:0]             r_ny;
    logic [CELL_W-1:0]          r_ocr, r_occ;
    logic                       r_olast;

    logic                       out_take;
    logic                       job_take;
    logic signed [DIFF_W-1:0]   neg_dx, neg_dz;
    logic [MAG_W-1:0]           mul_a;
    logic [SQ_W-1:0]            product;
    logic [REM_W-1:0]           div_cand;
    logic [SREM_W+1:0]          sqrt_a;
    logic [SREM_W-1:0]          sqrt_trial;
    logic [REM_W-1:0]           sub_a, sub_b;
    logic [REM_W:0]             sub_diff;
    logic                       sub_ge;
    logic [ROOT_W:0]            root_inc;
    logic [Q_W-1:0]             q_new;
    t_comp                      ld_comp;
    logic [REM_W-1:0]           ld_v2;
    logic                       ld_div;

    assign out_take = r_out_valid && o_normal.ready;
    assign job_take = (r_state == N_IDLE) && i_job_valid;
    assign o_busy   = (r_state != N_IDLE);

    // Magnitudes of the corner difference sums
    assign neg_dx = -i_job.dx;
    assign neg_dz = -i_job.dz;

    // Shared squarer
    assign mul_a   = (r_state == N_SQZ) ? r_adz : r_adx;
    assign product = SQ_W'(mul_a) * SQ_W'(mul_a);

    // Shared compare-subtract unit: division step or square root step
    assign div_cand   = (r_step == '0) ? r_rem : {r_rem[REM_W-2:0], 1'b0};
    assign sqrt_a     = {r_rem[SREM_W-1:0], r_quo[QUO_W-1 -: 2]};
    assign sqrt_trial = {r_root, 2'b01};
    assign sub_a      = (r_state == N_DIV) ? div_cand : REM_W'(sqrt_a);
    assign sub_b      = (r_state == N_DIV) ? REM_W'(r_s) : REM_W'(sqrt_trial);
    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge     = !sub_diff[REM_W];

    // Round the root to the output scale
    assign root_inc = {1'b0, r_root} + (ROOT_W+1)'(1);
    assign q_new    = root_inc[Q_W:1];

    // Pick the squared component that the next division starts from
    always_comb begin
        case (ld_comp)
            COMP_X:  ld_v2 = REM_W'(r_sqx);
            COMP_Y:  ld_v2 = REM_W'(Y_SQ);
            COMP_Z:  ld_v2 = REM_W'(r_sqz);
            default: ld_v2 = '0;
        endcase
    end

    // Sequencer and datapath next values
    always_comb begin
        n_state     = r_state;
        n_comp      = r_comp;
        n_step      = r_step;
        n_sqx       = r_sqx;
        n_sqz       = r_sqz;
        n_s         = r_s;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_root      = r_root;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_qz        = r_qz;
        n_out_valid = r_out_valid;
        out_load    = 1'b0;
        ld_div      = 1'b0;
        ld_comp     = COMP_X;

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            N_IDLE: begin
                if (job_take) begin
                    n_state = N_SQX;
                end
            end
            N_SQX: begin
                n_sqx   = product;
                n_state = N_SQZ;
            end
            N_SQZ: begin
                n_sqz   = product;
                n_state = N_SUM;
            end
            N_SUM: begin
                n_s     = SUM_W'(r_sqx) + SUM_W'(r_sqz) + SUM_W'(Y_SQ);
                ld_comp = COMP_X;
                ld_div  = 1'b1;
            end
            N_DIV: begin
                // One quotient bit per cycle
                if (sub_ge) begin
                    n_rem = sub_diff[REM_W-1:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = div_cand;
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = N_SQRT;
                    n_step  = '0;
                    n_rem   = '0;
                    n_root  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            N_SQRT: begin
                // One root bit per cycle, two radicand bits shifted in
                if (sub_ge) begin
                    n_rem  = REM_W'(sub_diff[SREM_W-1:0]);
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = REM_W'(sqrt_a[SREM_W-1:0]);
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_quo = {r_quo[QUO_W-3:0], 2'b00};
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = N_STORE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            N_STORE: begin
                case (r_comp)
                    COMP_X: begin
                        n_qx    = q_new;
                        ld_comp = COMP_Y;
                        ld_div  = 1'b1;
                    end
                    COMP_Y: begin
                        n_qy    = q_new;
                        ld_comp = COMP_Z;
                        ld_div  = 1'b1;
                    end
                    default: begin
                        n_qz    = q_new;
                        n_state = N_DONE;
                    end
                endcase
            end
            N_DONE: begin
                // Move the result into the output register once it is free
                if (!r_out_valid || out_take) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = N_IDLE;
                end
            end
            default: begin
                n_state = N_IDLE;
            end
        endcase

        // Start the division for a component
        if (ld_div) begin
            n_state = N_DIV;
            n_comp  = ld_comp;
            n_step  = '0;
            n_rem   = ld_v2;
            n_quo   = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= N_IDLE;
            r_comp      <= COMP_X;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_comp      <= n_comp;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_adx   <= i_job.dx[DIFF_W-1] ? neg_dx[MAG_W-1:0] : i_job.dx[MAG_W-1:0];
            r_adz   <= i_job.dz[DIFF_W-1] ? neg_dz[MAG_W-1:0] : i_job.dz[MAG_W-1:0];
            r_neg_x <= !i_job.dx[DIFF_W-1];
            r_neg_z <= !i_job.dz[DIFF_W-1];
            r_row   <= i_job.row;
            r_col   <= i_job.col;
            r_last  <= i_job.last;
        end
        r_sqx  <= n_sqx;
        r_sqz  <= n_sqz;
        r_s    <= n_s;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_root <= n_root;
        r_qx   <= n_qx;
        r_qy   <= n_qy;
        r_qz   <= n_qz;
    end

    // Output register, signs applied on load
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_nx    <= r_neg_x ? (OUT_W'(0) - OUT_W'(r_qx)) : OUT_W'(r_qx);
            r_ny    <= r_qy;
            r_nz    <= r_neg_z ? (OUT_W'(0) - OUT_W'(r_qz)) : OUT_W'(r_qz);
            r_ocr   <= r_row;
            r_occ   <= r_col;
            r_olast <= r_last;
        end
    end

    assign o_normal.valid     = r_out_valid;
    assign o_normal.normal_x  = r_nx;
    assign o_normal.normal_y  = r_ny;
    assign o_normal.normal_z  = r_nz;
    assign o_normal.cell_row  = r_ocr;
    assign o_normal.cell_col  = r_occ;
    assign o_normal.last_cell = r_olast;

endmodule

`default_nettype wire

@@ src/heightmap_surface_normal.sv @@
// Top level of the streaming heightmap surface normal block
//
//  channel    dir  payload                                           takes place when
//  i_cfg      in   grid_size                                         valid && ready
//  i_sample   in   height_sample, grid_start                         valid && ready
//  o_normal   out  normal_x/y/z, cell_row, cell_col, last_cell       valid && ready
//
//  A sample in row 0 or column 0 makes no cell and only passes the tracker's read and calc states.
//  A sample that completes a cell passes the row store read and the corner sums, the squaring
//  of x and z and their sum, then per component 31 divide steps, 16 square root steps and 1
//  store on the shared compare-subtract unit, and last the load of the output register.
//  Reset is synchronous and active low; the row store has no reset and needs no clearing.
//  A stalled output holds in its register while the next sample is taken and worked on.
`default_nettype none

module heightmap_surface_normal (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hsn_cfg_if.sink         i_cfg,
    hsn_sample_if.sink      i_sample,
    hsn_normal_if.source    o_normal
);
    import hsn_pkg::*;

    logic       job_valid;
    t_cell_job  job;
    logic       norm_busy;

    // Position tracking and corner sums
    hsn_grid_track u_grid_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_sample    (i_sample),
        .i_norm_busy (norm_busy),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // Normalization and output register
    hsn_normalize u_normalize (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_busy      (norm_busy),
        .o_normal    (o_normal)
    );

endmodule

`default_nettype wire

@@ src/hsn_checker.sv @@
// Port-level checks of the heightmap surface normal block and their binding
`default_nettype none

`include "heightmap_surface_normal_assert.svh"

module hsn_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [hsn_pkg::OUT_W-1:0]    i_normal_x,
    input  logic [hsn_pkg::Q_W-1:0]             i_normal_y,
    input  logic signed [hsn_pkg::OUT_W-1:0]    i_normal_z,
    input  logic [hsn_pkg::CELL_W-1:0]          i_cell_row,
    input  logic [hsn_pkg::CELL_W-1:0]          i_cell_col,
    input  logic                                i_last_cell
);
    import hsn_pkg::*;

    // Hold a stalled request and its payload
    `HSN_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_normal_x) && $stable(i_normal_y) && $stable(i_normal_z) && $stable(i_cell_row) && $stable(i_cell_col) && $stable(i_last_cell), "stalled normal request changed")

    // Drop input ready right after a sample is taken
    `HSN_ASSERT_NEXT(a_one_sample, i_in_valid && i_in_ready, !i_in_ready, "sample taken while busy")

    // Keep the height component positive and at most one
    `HSN_ASSERT_SAME(a_y_range, i_out_valid, i_normal_y != '0 && i_normal_y <= Q_W'(1 << 14), "normal_y out of range")

    // The last cell lies on the diagonal
    `HSN_ASSERT_SAME(a_last_diag, i_out_valid && i_last_cell, i_cell_row == i_cell_col, "last cell off diagonal")

endmodule

bind heightmap_surface_normal hsn_checker u_hsn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_normal.valid),
    .i_out_ready (o_normal.ready),
    .i_normal_x  (o_normal.normal_x),
    .i_normal_y  (o_normal.normal_y),
    .i_normal_z  (o_normal.normal_z),
    .i_cell_row  (o_normal.cell_row),
    .i_cell_col  (o_normal.cell_col),
    .i_last_cell (o_normal.last_cell)
);

`default_nettype wire
